### src/nrmc_pkg.sv
// Shared types, character codes and arithmetic helpers for the RMC position parser.
// No dependencies.
`timescale 1ns / 1ps

package nrmc_pkg;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 30;
    localparam int HIST_W  = 20;
    localparam int FRAC_W  = 14;
    localparam int CNT_W   = 3;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
    localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h52;
    localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h53;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
    localparam logic [CHAR_W-1:0] CH_W      = 8'h57;

    // Field numbers (commas seen after the header)
    localparam logic [CNT_W-1:0] FLD_LAT     = 3'd3;
    localparam logic [CNT_W-1:0] FLD_LAT_DIR = 3'd4;
    localparam logic [CNT_W-1:0] FLD_LON     = 3'd5;
    localparam logic [CNT_W-1:0] FLD_LON_DIR = 3'd6;
    localparam logic [CNT_W-1:0] CNT_MAX     = 3'd7;
    localparam logic [CNT_W-1:0] FRAC_DONE   = 3'd5;  // dot plus four digits
    localparam logic [CNT_W-1:0] WIDE_DEG    = 3'd5;  // integer chars for 3 degree digits

    localparam logic [POS_W-1:0] UNITS_DEG = 30'd600000;
    localparam logic [POS_W-1:0] UNITS_MIN = 30'd10000;

    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_G,
        HDR_P,
        HDR_R,
        HDR_M,
        HDR_C,
        HDR_BODY
    } t_hdr;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = c - CH_ZERO;
            digit_of = (c >= CH_ZERO && c <= CH_NINE) ? d[DIGIT_W-1:0] : '0;
        end
    endfunction

    function automatic logic is_hemi(input logic [CHAR_W-1:0] c);
        is_hemi = (c == CH_N) || (c == CH_S) || (c == CH_E) || (c == CH_W);
    endfunction

    // Walk one step through the G P R M C header, back to idle on a mismatch.
    function automatic t_hdr hdr_advance(input t_hdr s, input logic [CHAR_W-1:0] c);
        t_hdr nxt;
        begin
            nxt = HDR_IDLE;
            unique case (s)
                HDR_G:   if (c == CH_G) nxt = HDR_P;
                HDR_P:   if (c == CH_P) nxt = HDR_R;
                HDR_R:   if (c == CH_R) nxt = HDR_M;
                HDR_M:   if (c == CH_M) nxt = HDR_C;
                HDR_C:   if (c == CH_C) nxt = HDR_BODY;
                default: nxt = s;
            endcase
            hdr_advance = nxt;
        end
    endfunction

    // degrees*600000 + minutes*10000 + fractional minutes (scaled to 4 digits)
    function automatic logic [POS_W-1:0] field_position(
        input logic [HIST_W-1:0] hist,
        input logic [CNT_W-1:0]  int_cnt,
        input logic [CNT_W-1:0]  frac_cnt,
        input logic [FRAC_W-1:0] frac
    );
        logic [9:0]       deg;
        logic [6:0]       mins;
        logic [POS_W-1:0] frac_sc;
        begin
            deg = 10'(hist[15:12]) * 10'd10 + 10'(hist[11:8]);
            if (int_cnt >= WIDE_DEG) deg = deg + 10'(hist[19:16]) * 10'd100;
            mins = 7'(hist[7:4]) * 7'd10 + 7'(hist[3:0]);
            unique case (frac_cnt)
                3'd1:    frac_sc = POS_W'(frac) * 30'd10000;
                3'd2:    frac_sc = POS_W'(frac) * 30'd1000;
                3'd3:    frac_sc = POS_W'(frac) * 30'd100;
                3'd4:    frac_sc = POS_W'(frac) * 30'd10;
                default: frac_sc = POS_W'(frac);
            endcase
            field_position = POS_W'(deg) * UNITS_DEG + POS_W'(mins) * UNITS_MIN + frac_sc;
        end
    endfunction

endpackage

### src/nmea_rmc_position_parser.sv
// NMEA RMC position parser top level: input register, single-pass character
// decode and a result register. Depends on nrmc_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Beat carries
// input     in         i_valid / o_ready   i_char_in: one received character
// result    out        o_valid / i_ready   o_latitude, o_longitude,
//                                          o_lat_hemisphere, o_lon_hemisphere
//
// One character per cycle is taken while the result side is not stalled.
// A character is decoded against the parser state while it sits in the
// input register, and a position result is loaded into the output register
// when the character that closed it is decoded.
// A stalled result blocks decoding, and the input register then holds its beat
// while o_ready drops; the input side keeps moving while the result is taken.
// Reset (i_rst_n low at a clock edge) clears all parser state and both valid flags.

module nmea_rmc_position_parser
    import nrmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [POS_W-1:0]  o_latitude,
    output logic [POS_W-1:0]  o_longitude,
    output logic [CHAR_W-1:0] o_lat_hemisphere,
    output logic [CHAR_W-1:0] o_lon_hemisphere
);

    // input stage
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_char;

    // parser state
    t_hdr              r_hdr,  n_hdr;
    logic [CNT_W-1:0]  r_fld,  n_fld;
    logic [HIST_W-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]  r_icnt, n_icnt;
    logic [CNT_W-1:0]  r_fcnt, n_fcnt;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [POS_W-1:0]  r_lat,  n_lat;
    logic [POS_W-1:0]  r_lon,  n_lon;
    logic [CHAR_W-1:0] r_latd, n_latd;
    logic [CHAR_W-1:0] r_lond, n_lond;

    // result stage
    logic              r_out_vld;
    logic [POS_W-1:0]  r_o_lat, r_o_lon;
    logic [CHAR_W-1:0] r_o_latd, r_o_lond;

    logic              step;   // decode the held character this cycle
    logic              emit;   // decoded character closes a sentence
    logic [POS_W-1:0]  pos;

    // Decode only when the result register can take whatever comes out.
    assign step    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || step;

    assign pos = field_position(r_hist, r_icnt, r_fcnt, r_frac);

    // Input register: load a new beat whenever it is empty or the held one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
        end
    end

    // Header state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= HDR_IDLE;
        end else begin
            r_hdr <= n_hdr;
        end
    end

    // Next state for header, field counters, number accumulators and captures.
    always_comb begin
        n_hdr  = r_hdr;
        n_fld  = r_fld;
        n_hist = r_hist;
        n_icnt = r_icnt;
        n_fcnt = r_fcnt;
        n_frac = r_frac;
        n_lat  = r_lat;
        n_lon  = r_lon;
        n_latd = r_latd;
        n_lond = r_lond;
        emit   = 1'b0;
        if (step) begin
            priority if (r_char == CH_DOLLAR) begin
                // restart: drop everything from the previous sentence
                n_hdr  = HDR_G;
                n_fld  = '0;
                n_hist = '0;
                n_icnt = '0;
                n_fcnt = '0;
                n_frac = '0;
                n_lat  = '0;
                n_lon  = '0;
                n_latd = '0;
                n_lond = '0;
            end else if (r_hdr == HDR_IDLE) begin
                n_hdr = HDR_IDLE;
            end else if (r_hdr != HDR_BODY) begin
                n_hdr = hdr_advance(r_hdr, r_char);
            end else if (r_char == CH_COMMA) begin
                // commit a position only if its field had a decimal point
                if (r_fcnt != '0) begin
                    if (r_fld == FLD_LAT) n_lat = pos;
                    if (r_fld == FLD_LON) n_lon = pos;
                end
                n_hist = '0;
                n_icnt = '0;
                n_fcnt = '0;
                n_frac = '0;
                if (r_fld != CNT_MAX) n_fld = r_fld + 1'b1;
            end else if (r_fld == FLD_LAT || r_fld == FLD_LON) begin
                if (r_fcnt == '0) begin
                    if (r_char == CH_DOT) begin
                        n_fcnt = 3'd1;
                    end else begin
                        n_hist = {r_hist[HIST_W-DIGIT_W-1:0], digit_of(r_char)};
                        if (r_icnt != CNT_MAX) n_icnt = r_icnt + 1'b1;
                    end
                end else if (r_char != CH_DOT && r_fcnt < FRAC_DONE) begin
                    n_frac = FRAC_W'(r_frac * 4'd10) + FRAC_W'(digit_of(r_char));
                    n_fcnt = r_fcnt + 1'b1;
                end
            end else if (r_fld == FLD_LAT_DIR) begin
                if (is_hemi(r_char)) n_latd = r_char;
            end else if (r_fld == FLD_LON_DIR) begin
                if (is_hemi(r_char)) begin
                    n_lond = r_char;
                    emit   = 1'b1;
                    n_hdr  = HDR_IDLE;
                end
            end
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld  <= '0;
            r_hist <= '0;
            r_icnt <= '0;
            r_fcnt <= '0;
            r_frac <= '0;
            r_lat  <= '0;
            r_lon  <= '0;
            r_latd <= '0;
            r_lond <= '0;
        end else begin
            r_fld  <= n_fld;
            r_hist <= n_hist;
            r_icnt <= n_icnt;
            r_fcnt <= n_fcnt;
            r_frac <= n_frac;
            r_lat  <= n_lat;
            r_lon  <= n_lon;
            r_latd <= n_latd;
            r_lond <= n_lond;
        end
    end

    // Result register: hold until taken, reload on a new sentence end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= emit;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (emit) begin
            r_o_lat  <= r_lat;
            r_o_lon  <= r_lon;
            r_o_latd <= r_latd;
            r_o_lond <= r_char;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_latitude       = r_o_lat;
    assign o_longitude      = r_o_lon;
    assign o_lat_hemisphere = r_o_latd;
    assign o_lon_hemisphere = r_o_lond;

    // A sentence end always sends the header back to waiting for a dollar.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_hdr == HDR_IDLE))
        else $error("header not idle after sentence end");

    // A new result only appears right after a decode step.
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(step))
        else $error("result appeared without a decode step");

    // Fraction count never passes the dot plus four digits.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FRAC_DONE)
        else $error("fraction digit count out of range");

    // Input side only stalls when a character is held.
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_vld)
        else $error("input stalled with empty input register");

endmodule

### tb/nmea_rmc_position_parser_tb.sv
// Self-checking bench for nmea_rmc_position_parser: streams RMC sentences and noise
// through the character channel and checks every position beat against a parser copy.
// Depends on nrmc_pkg and the parser RTL.
`timescale 1ns / 1ps

module nmea_rmc_position_parser_tb
    import nrmc_pkg::*;
();

    // Total characters to send, directed sentences included.
    localparam int TOTAL_CHARS  = 1700;
    // Drop all idling once this few characters are left to send.
    localparam int TAIL_CHARS   = 300;
    // Cycles to watch for stray beats after the last expected fix.
    localparam int DRAIN_CYCLES = 16;
    // Roughly 1700 characters with random idle gaps and result stalls; the limit
    // leaves a wide margin over what they need.
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    // Parser state, mirrored at the block's own widths.
    typedef struct packed {
        t_hdr               hdr;
        logic [CNT_W-1:0]   fields;
        logic [HIST_W-1:0]  hist;
        logic [CNT_W-1:0]   int_cnt;
        logic [CNT_W-1:0]   frac_cnt;
        logic [FRAC_W-1:0]  frac;
        logic [POS_W-1:0]   lat;
        logic [POS_W-1:0]   lon;
        logic [CHAR_W-1:0]  lat_dir;
        logic [CHAR_W-1:0]  lon_dir;
    } t_parser_state;

    // One position fix as it leaves the block.
    typedef struct packed {
        logic [POS_W-1:0]  lat;
        logic [POS_W-1:0]  lon;
        logic [CHAR_W-1:0] lat_hemi;
        logic [CHAR_W-1:0] lon_hemi;
    } t_rmc_fix;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              i_ready   = 1'b0;
    logic [CHAR_W-1:0] i_char_in = '0;
    logic              o_ready;
    logic              o_valid;
    logic [POS_W-1:0]  o_latitude;
    logic [POS_W-1:0]  o_longitude;
    logic [CHAR_W-1:0] o_lat_hemisphere;
    logic [CHAR_W-1:0] o_lon_hemisphere;

    // Characters not yet accepted, and fixes the block still owes us.
    logic [CHAR_W-1:0] pending_chars[$];
    t_rmc_fix          pending_fixes[$];

    // Parser copy that follows accepted beats to predict what the block emits.
    t_parser_state live_state;
    t_rmc_fix      live_fix;
    t_rmc_fix      seen_fix;
    t_rmc_fix      want_fix;

    int          mismatches    = 0;
    int          cycle_cnt     = 0;
    int          in_gap        = 0;
    int          rdy_gap       = 0;
    bit          cur_valid     = 1'b0;
    bit          beat_taken    = 1'b0;
    bit          calm          = 1'b0;
    bit          quiet         = 1'b0;
    logic [CHAR_W-1:0] cur_char = '0;

    always #5 i_clk = ~i_clk;

    nmea_rmc_position_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_in        (i_char_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_latitude       (o_latitude),
        .o_longitude      (o_longitude),
        .o_lat_hemisphere (o_lat_hemisphere),
        .o_lon_hemisphere (o_lon_hemisphere)
    );

    // Advance the parser by one character; return 1 with the fix when the
    // longitude hemisphere closes the sentence.
    function automatic bit rmc_parse_char(inout t_parser_state s,
                                          input logic [CHAR_W-1:0] c,
                                          output t_rmc_fix fix);
        logic [DIGIT_W-1:0] dval;
        logic [CHAR_W-1:0]  want;
        logic [POS_W-1:0]   pos;
        bit                 hemi;
        int unsigned        deg;
        int unsigned        mins;
        int unsigned        frac_sc;
        int                 k;
        rmc_parse_char = 1'b0;
        fix  = '0;
        // anything that is not a decimal digit counts as zero
        dval = (c >= CH_ZERO && c <= CH_NINE) ? DIGIT_W'(c - CH_ZERO) : '0;
        hemi = (c == CH_N) || (c == CH_S) || (c == CH_E) || (c == CH_W);
        if (c == CH_DOLLAR) begin
            // a dollar wipes everything and starts a new header
            s     = '0;
            s.hdr = HDR_G;
        end else if (s.hdr != HDR_IDLE && s.hdr != HDR_BODY) begin
            case (s.hdr)
                HDR_G:   want = CH_G;
                HDR_P:   want = CH_P;
                HDR_R:   want = CH_R;
                HDR_M:   want = CH_M;
                default: want = CH_C;
            endcase
            s.hdr = (c == want) ? t_hdr'(s.hdr + 3'd1) : HDR_IDLE;
        end else if (s.hdr == HDR_BODY) begin
            if (c == CH_COMMA) begin
                // commit a position field only if it held a decimal point
                if (s.frac_cnt != '0 && (s.fields == FLD_LAT || s.fields == FLD_LON)) begin
                    deg = s.hist[15:12] * 10 + s.hist[11:8];
                    if (s.int_cnt >= WIDE_DEG) deg = deg + s.hist[19:16] * 100;
                    mins    = s.hist[7:4] * 10 + s.hist[3:0];
                    frac_sc = s.frac;
                    // pad a short fraction out to four digits
                    for (k = int'(s.frac_cnt); k < FRAC_DONE; k++) frac_sc = frac_sc * 10;
                    pos = POS_W'(deg * UNITS_DEG + mins * UNITS_MIN + frac_sc);
                    if (s.fields == FLD_LAT) s.lat = pos;
                    else s.lon = pos;
                end
                s.hist     = '0;
                s.int_cnt  = '0;
                s.frac_cnt = '0;
                s.frac     = '0;
                if (s.fields != CNT_MAX) s.fields = s.fields + 3'd1;
            end else if (s.fields == FLD_LAT || s.fields == FLD_LON) begin
                if (s.frac_cnt == '0) begin
                    if (c == CH_DOT) begin
                        s.frac_cnt = 3'd1;
                    end else begin
                        s.hist = {s.hist[15:0], dval};
                        if (s.int_cnt != CNT_MAX) s.int_cnt = s.int_cnt + 3'd1;
                    end
                end else if (c != CH_DOT && s.frac_cnt < FRAC_DONE) begin
                    s.frac     = FRAC_W'(s.frac * 10 + dval);
                    s.frac_cnt = s.frac_cnt + 3'd1;
                end
            end else if (s.fields == FLD_LAT_DIR) begin
                if (hemi) s.lat_dir = c;
            end else if (s.fields == FLD_LON_DIR && hemi) begin
                s.lon_dir      = c;
                fix            = {s.lat, s.lon, s.lat_dir, s.lon_dir};
                s.hdr          = HDR_IDLE;
                rmc_parse_char = 1'b1;
            end
        end
    endfunction

    // Queue one character for the driver.
    task automatic push_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
    endtask

    task automatic push_text(input string t);
        int k;
        for (k = 0; k < t.len(); k++) push_char(t[k]);
    endtask

    function automatic string digit_text(input int n);
        string r;
        int    k;
        r = "";
        for (k = 0; k < n; k++) r = $sformatf("%s%0d", r, $urandom_range(0, 9));
        return r;
    endfunction

    // [d]ddmm.ffff with random widths; now and then no point or a stray letter.
    function automatic string number_text(input int int_len);
        string r;
        int    pick;
        r    = digit_text(int_len);
        pick = $urandom_range(0, 15);
        if (pick == 0) return r;
        if (pick == 1) r = $sformatf("%s%c", r, $urandom_range(65, 90));
        return {r, ".", digit_text($urandom_range(0, 6))};
    endfunction

    // Usually one letter of the expected pair; sometimes missing, foreign or
    // led by junk.
    function automatic string hemi_text(input string pair);
        string all_hemi;
        int    idx;
        all_hemi = "NSEW";
        case ($urandom_range(0, 11))
            0: return "";
            1: return {"Q", pair.substr(1, 1)};
            2: begin
                idx = $urandom_range(0, 3);
                return all_hemi.substr(idx, idx);
            end
            default: begin
                idx = $urandom_range(0, 1);
                return pair.substr(idx, idx);
            end
        endcase
    endfunction

    // A full RMC sentence with random content; about a third get broken.
    task automatic push_sentence();
        string             t;
        logic [CHAR_W-1:0] b[$];
        int                k;
        int                cut;
        int                lat_len;
        int                lon_len;
        lat_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 4;
        lon_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 5;
        t = {"$GPRMC,", digit_text(6), ".00,A,", number_text(lat_len), ",",
             hemi_text("NS"), ",", number_text(lon_len), ",", hemi_text("EW"), ",",
             digit_text(3), ".", digit_text(1), ",", digit_text(6), ",,*", digit_text(2)};
        for (k = 0; k < t.len(); k++) b.push_back(t[k]);
        b.push_back(8'h0D);
        b.push_back(8'h0A);
        case ($urandom_range(0, 9))
            0: b[$urandom_range(0, b.size() - 1)] = CHAR_W'($urandom_range(0, 255));
            1: begin
                cut = $urandom_range(1, b.size() - 1);
                while (b.size() > cut) void'(b.pop_back());
            end
            2: b[$urandom_range(1, 5)] = CHAR_W'($urandom_range(65, 90));
            default: ;
        endcase
        for (k = 0; k < b.size(); k++) push_char(b[k]);
    endtask

    // Character driver: present the head of the queue, hold it until the beat
    // is taken, and insert random idle bursts except in calm stretches and the tail.
    always @(negedge i_clk) begin
        if (beat_taken) begin
            cur_valid  = 1'b0;
            beat_taken = 1'b0;
        end
        if (i_rst_n && !cur_valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_chars.size() > 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 12);
                end else begin
                    cur_valid = 1'b1;
                    cur_char  = pending_chars[0];
                end
            end
        end
        i_valid   <= cur_valid;
        i_char_in <= cur_char;
    end

    // Result sink: stall in random bursts, ready otherwise.
    always @(negedge i_clk) begin
        if (rdy_gap > 0) begin
            rdy_gap--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rdy_gap = $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: check the result beat first, then predict from the character
    // beat, so a fix is never pushed and popped out of order in one edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_fix = {o_latitude, o_longitude, o_lat_hemisphere, o_lon_hemisphere};
            if (pending_fixes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: stray result lat %0d lon %0d hemi %02h/%02h",
                             cycle_cnt, seen_fix.lat, seen_fix.lon,
                             seen_fix.lat_hemi, seen_fix.lon_hemi);
            end else begin
                want_fix = pending_fixes.pop_front();
                if (seen_fix.lat !== want_fix.lat || seen_fix.lon !== want_fix.lon ||
                    seen_fix.lat_hemi !== want_fix.lat_hemi ||
                    seen_fix.lon_hemi !== want_fix.lon_hemi) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display(
                            "cycle %0d exp/act: lat %0d/%0d lon %0d/%0d hemi %02h/%02h %02h/%02h",
                            cycle_cnt, want_fix.lat, seen_fix.lat,
                            want_fix.lon, seen_fix.lon,
                            want_fix.lat_hemi, seen_fix.lat_hemi,
                            want_fix.lon_hemi, seen_fix.lon_hemi);
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            void'(pending_chars.pop_front());
            if (rmc_parse_char(live_state, i_char_in, live_fix))
                pending_fixes.push_back(live_fix);
            beat_taken = 1'b1;
        end
        // switch calm stretches on and off; go calm for good near the end
        if (cycle_cnt % 200 == 0) calm = ($urandom_range(0, 3) == 0);
        quiet = calm || (pending_chars.size() < TAIL_CHARS);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("nmea_rmc_position_parser_tb failed");
            $finish;
        end
    end

    initial begin
        live_state = '0;

        // Directed sentences.
        push_char(8'h00);
        push_char(8'hFF);
        // widest values, three degree digits
        push_text("$GPRMC,,,9999.9999,N,99999.9999,E");
        // all zero
        push_text("$GPRMC,,,0000.0000,S,00000.0000,W");
        // short fraction and a bare point
        push_text("$GPRMC,,,4807.03,N,01131.,E");
        // fraction overrun with a second point; last latitude letter wins;
        // junk ahead of the closing letter
        push_text("$GPRMC,,,4807.038247.1,NXS,01131.0000,xW");
        // no point in either field, no latitude letter
        push_text("$GPRMC,,,4807,Q,011310000,E");
        // non-digits inside numbers; integer count saturates
        push_text("$GPRMC,,,4A7.0x3,N,1234567890.5,W");
        // short integer parts
        push_text("$GPRMC,,,12.5,S,1.25,E");
        // broken and foreign headers give nothing
        push_text("$GPRMX,,,1234.5,N,12345.6,E");
        push_text("$GPGGA,,,1234.5,N,12345.6,E");
        push_text("$gprmc,,,1234.5,N,12345.6,E");
        // dollar restarts, in the header and in the body; letter after the fix ignored
        push_text("$GP$GPRMC,,,1234.5,N,$GPRMC,,,2345.6,S,34567.8,E,W");
        // letter lands past the longitude-letter field
        push_text("$GPRMC,,,1111.1,N,22222.2,,E");
        // excess commas
        push_text("$GPRMC,A,B,C,D,E,F,G,H,N");
        // leading noise, swapped letters
        push_text("xyz$GPRMC,,,3030.3030,E,15045.4545,N\r\n");

        // Random traffic: mostly sentences, some broken, noise in between.
        while (pending_chars.size() < TOTAL_CHARS) begin
            repeat ($urandom_range(0, 3)) push_char(CHAR_W'($urandom_range(0, 255)));
            push_sentence();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || pending_fixes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_fixes.size() == 0) begin
            $display("nmea_rmc_position_parser_tb passed");
        end else begin
            $display("nmea_rmc_position_parser_tb failed");
        end
        $finish;
    end

endmodule
